@@ sv/apr_pkg.sv @@
// shared types and constants for the addressed packet receiver
`timescale 1ns / 1ps
`default_nettype none

package apr_pkg;

	localparam logic [7:0]  PREAMBLE_END = 8'h55;
	localparam logic [7:0]  SIZE_MASK    = 8'h0F;
	localparam logic [15:0] CRC_POLY     = 16'h1021;
	localparam logic [15:0] CRC_START    = 16'h0000;
	localparam logic [15:0] CRC_RESET    = 16'hFFFF;

	localparam int STORE_DEPTH     = 16;
	localparam int STORE_AW        = $clog2(STORE_DEPTH);
	localparam int DIGIT_BITS      = 2;
	localparam int DIGITS_PER_BYTE = 8 / DIGIT_BITS;
	localparam int DIGIT_CW        = $clog2(DIGITS_PER_BYTE);

	typedef enum logic [2:0] {
		PH_NOISE,
		PH_PREAMBLE,
		PH_ADDRESS,
		PH_SIZE,
		PH_DATA,
		PH_CHECK1,
		PH_CHECK2
	} phase_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_CRC,
		ENG_RD,
		ENG_LD
	} eng_t;

	typedef struct packed {
		logic start;
		logic clr;
	} crc_ctl_t;

	typedef struct packed {
		logic busy;
		logic zero;
	} crc_stat_t;

endpackage

`default_nettype wire

@@ sv/apr_crc_serial.sv @@
// crc-16 xmodem unit, two message bits per cycle, msb first
`timescale 1ns / 1ps
`default_nettype none

module apr_crc_serial
	import apr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire crc_ctl_t  ctl,
	input  wire logic [7:0] data,
	output crc_stat_t      stat
);

	logic [15:0]         crc_q;
	logic [7:0]          sh_q;
	logic [DIGIT_CW-1:0] cnt_q;
	logic                busy_q;
	logic [15:0]         crc_nx;
	logic                fb;

	// fold one digit of the shift register into the accumulator
	always_comb begin
		crc_nx = crc_q;
		fb = 1'b0;
		for (int k = 0; k < DIGIT_BITS; k++) begin
			fb = crc_nx[15] ^ sh_q[7-k];
			crc_nx = {crc_nx[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_RESET;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (busy_q) begin
			crc_q <= crc_nx;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIGIT_CW'(DIGITS_PER_BYTE - 1))
				busy_q <= 1'b0;
		end else if (ctl.start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (ctl.clr) begin
			crc_q <= CRC_START;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && ctl.start)
			sh_q <= data;
		else if (busy_q)
			sh_q <= {sh_q[7-DIGIT_BITS:0], {DIGIT_BITS{1'b0}}};
	end

	assign stat.busy = busy_q;
	assign stat.zero = (crc_q == 16'h0000);

endmodule

`default_nettype wire

@@ sv/apr_store.sv @@
// payload store, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module apr_store
	import apr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [STORE_AW-1:0] wr_addr,
	input  wire logic [7:0]          wr_data,
	input  wire logic                rd_en,
	input  wire logic [STORE_AW-1:0] rd_addr,
	output logic [7:0]               rd_data
);

	logic [7:0] mem [STORE_DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ sv/addressed_packet_receiver_crc16.sv @@
// top level: frame hunting, address filter, payload capture and release
//
//  channel   signals                                   direction
//  input     in_valid, in_stall, rx_byte               byte request in
//  output    out_valid, out_stall, payload_byte,       payload request out
//            last_byte
//  config    cfg_valid, cfg_ready, device_addr         address write in
//
// preamble, address and size bytes are taken by the idle engine; payload and
// check bytes also run the 2-bit-per-cycle crc digit loop, stalling input.
// a packet that passes releases its payload a byte at a time, each read
// via the registered read port of the payload store; input stalls meanwhile.
// arst_n clears control state; the crc accumulator resets to all ones.
// a stalled result sits in the output register while the next byte is taken.
`timescale 1ns / 1ps
`default_nettype none

module addressed_packet_receiver_crc16
	import apr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      payload_byte,
	output logic            last_byte,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] device_addr
);

	phase_t              phase_q, phase_d;
	eng_t                eng_q, eng_d;
	logic [4:0]          bytes_left_q, bytes_left_d;
	logic [4:0]          payload_len_q, payload_len_d;
	logic                final_q, final_d;
	logic [STORE_AW-1:0] rd_idx_q, rd_idx_d;
	logic [7:0]          dev_addr_q;
	logic                out_valid_q, out_valid_d;
	logic [7:0]          payload_byte_q;
	logic                last_byte_q;

	logic                accept;
	logic                addr_match;
	logic                load_out;
	logic                is_last;
	logic                wr_en;
	logic                rd_en;
	logic [STORE_AW-1:0] wr_addr;
	logic [7:0]          rd_data;
	crc_ctl_t            crc_ctl;
	crc_stat_t           crc_st;

	assign cfg_ready = 1'b1;
	assign in_stall  = (eng_q != ENG_IDLE);
	assign accept    = in_valid && !in_stall;

	assign addr_match = (rx_byte == dev_addr_q) || (dev_addr_q == 8'h00) || (rx_byte == 8'h00);
	assign wr_addr    = STORE_AW'(payload_len_q - bytes_left_q);
	assign is_last    = ({1'b0, rd_idx_q} == (payload_len_q - 5'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_NOISE;
			eng_q         <= ENG_IDLE;
			bytes_left_q  <= '0;
			payload_len_q <= '0;
			final_q       <= 1'b0;
			rd_idx_q      <= '0;
			dev_addr_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			phase_q       <= phase_d;
			eng_q         <= eng_d;
			bytes_left_q  <= bytes_left_d;
			payload_len_q <= payload_len_d;
			final_q       <= final_d;
			rd_idx_q      <= rd_idx_d;
			out_valid_q   <= out_valid_d;
			if (cfg_valid && cfg_ready)
				dev_addr_q <= device_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			payload_byte_q <= rd_data;
			last_byte_q    <= is_last;
		end
	end

	always_comb begin
		phase_d       = phase_q;
		eng_d         = eng_q;
		bytes_left_d  = bytes_left_q;
		payload_len_d = payload_len_q;
		final_d       = final_q;
		rd_idx_d      = rd_idx_q;
		crc_ctl       = '0;
		wr_en         = 1'b0;
		rd_en         = 1'b0;
		load_out      = 1'b0;
		out_valid_d   = out_valid_q && out_stall;

		case (eng_q)
			ENG_IDLE: begin
				if (accept) begin
					case (phase_q)
						PH_NOISE: begin
							if (rx_byte == 8'h00)
								phase_d = PH_PREAMBLE;
						end
						PH_PREAMBLE: begin
							if (rx_byte != 8'h00)
								phase_d = (rx_byte == PREAMBLE_END) ? PH_ADDRESS : PH_NOISE;
						end
						PH_ADDRESS: begin
							phase_d = addr_match ? PH_SIZE : PH_NOISE;
						end
						PH_SIZE: begin
							payload_len_d = 5'(rx_byte & SIZE_MASK) + 5'd1;
							bytes_left_d  = 5'(rx_byte & SIZE_MASK) + 5'd1;
							crc_ctl.clr   = 1'b1;
							phase_d       = PH_DATA;
						end
						PH_DATA: begin
							wr_en         = 1'b1;
							crc_ctl.start = 1'b1;
							final_d       = 1'b0;
							eng_d         = ENG_CRC;
							bytes_left_d  = bytes_left_q - 5'd1;
							if (bytes_left_q == 5'd1)
								phase_d = PH_CHECK1;
						end
						PH_CHECK1: begin
							crc_ctl.start = 1'b1;
							final_d       = 1'b0;
							eng_d         = ENG_CRC;
							phase_d       = PH_CHECK2;
						end
						PH_CHECK2: begin
							crc_ctl.start = 1'b1;
							final_d       = 1'b1;
							eng_d         = ENG_CRC;
							phase_d       = PH_NOISE;
						end
						default: begin
							phase_d = PH_NOISE;
						end
					endcase
				end
			end
			ENG_CRC: begin
				if (!crc_st.busy) begin
					// release the packet only after the second check byte leaves zero
					if (final_q && crc_st.zero) begin
						rd_idx_d = '0;
						eng_d    = ENG_RD;
					end else begin
						eng_d = ENG_IDLE;
					end
				end
			end
			ENG_RD: begin
				rd_en = 1'b1;
				eng_d = ENG_LD;
			end
			ENG_LD: begin
				if (!out_valid_q || !out_stall) begin
					load_out    = 1'b1;
					out_valid_d = 1'b1;
					if (is_last) begin
						eng_d = ENG_IDLE;
					end else begin
						rd_idx_d = rd_idx_q + 1'b1;
						eng_d    = ENG_RD;
					end
				end
			end
			default: begin
				eng_d = ENG_IDLE;
			end
		endcase
	end

	apr_crc_serial u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.data   (rx_byte),
		.stat   (crc_st)
	);

	apr_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (rx_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	assign out_valid    = out_valid_q;
	assign payload_byte = payload_byte_q;
	assign last_byte    = last_byte_q;

`ifndef ASSERT_OFF
	// the crc digit loop only runs while the engine waits on it
	a_crc_busy_in_crc: assert property (@(posedge clk) disable iff (!arst_n)
		crc_st.busy |-> eng_q == ENG_CRC)
		else $error("crc unit busy outside crc wait");

	// payload writes happen only while capturing payload bytes
	a_write_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> phase_q == PH_DATA && eng_q == ENG_IDLE)
		else $error("payload store written outside data phase");

	// readout never runs past the captured length
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		eng_q == ENG_RD |-> {1'b0, rd_idx_q} < payload_len_q)
		else $error("payload readout beyond packet length");

	// a packet release always follows a finished crc wait
	a_release_after_crc: assert property (@(posedge clk) disable iff (!arst_n)
		eng_q == ENG_CRC && eng_d == ENG_RD |-> final_q && crc_st.zero && !crc_st.busy)
		else $error("payload released without a passing check");
`endif

endmodule

`default_nettype wire
